// ===== rtl/core/lcr_pkg.sv =====
// ============================================================================
// Load cell reader package
// Shared constants, codes and the job record passed from front to back end.
// ============================================================================
`default_nettype none

package lcr_pkg;

	localparam int RAW_BITS_DEF     = 24;
	localparam int EXTRA_PULSES_DEF = 1;
	localparam int RAW_MAX_W        = 32;
	localparam int OUT_W            = 24;
	localparam int GAP_W            = 16;
	localparam int EXT_W            = RAW_MAX_W + 1;
	localparam logic [GAP_W-1:0] GAP_RESET = 16'd213;

	typedef enum logic [1:0] {
		CMD_NONE  = 2'd0,
		CMD_TARE  = 2'd1,
		CMD_WEIGH = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_HIGH,
		PH_LOW
	} phase_t;

	typedef enum logic [1:0] {
		BK_RUN,
		BK_DIV,
		BK_DONE
	} back_state_t;

	// One job per accepted tick.
	typedef struct packed {
		logic                 clock_pin;
		logic                 busy;
		logic                 tare_done;
		logic                 div_req;
		logic [OUT_W-1:0]     raw;
		logic [RAW_MAX_W-1:0] diff;
	} job_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcr_front.sv =====
// ============================================================================
// Load cell reader front end
// Runs the two-wire converter sequence one tick per beat and emits a job.
// ============================================================================
`default_nettype none

module lcr_front #(
	parameter int RAW_BITS     = lcr_pkg::RAW_BITS_DEF,
	parameter int EXTRA_PULSES = lcr_pkg::EXTRA_PULSES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        tick_valid,
	output logic             tick_ready,
	input  wire logic [1:0]  command,
	input  wire logic        data_pin,
	input  wire logic        queue_full,
	output logic             push,
	output lcr_pkg::job_t    job
);

	localparam int TOTAL = RAW_BITS + EXTRA_PULSES;
	localparam int CNT_W = $clog2(TOTAL + 1);
	localparam logic [RAW_BITS-1:0] TOP_BIT = {1'b1, {(RAW_BITS-1){1'b0}}};

	lcr_pkg::phase_t phase_q, phase_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;
	logic [RAW_BITS-1:0] shift_q, shift_d;
	logic                tare_cmd_q, tare_cmd_d;
	logic [RAW_BITS-1:0] tare_q, tare_d;
	logic [RAW_BITS-1:0] last_raw_q, last_raw_d;
	logic [RAW_BITS-1:0] diff;
	logic [lcr_pkg::RAW_MAX_W-1:0] raw_ext;
	logic                clk_level;
	logic                tared;
	logic                div_req;
	lcr_pkg::cmd_t       cmd;

	assign cmd        = lcr_pkg::cmd_t'(command);
	assign tick_ready = !queue_full;
	assign push       = tick_valid && tick_ready;

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		shift_d    = shift_q;
		tare_cmd_d = tare_cmd_q;
		tare_d     = tare_q;
		last_raw_d = last_raw_q;
		clk_level  = 1'b0;
		tared      = 1'b0;
		div_req    = 1'b0;
		unique case (phase_q)
			lcr_pkg::PH_IDLE: begin
				if (cmd == lcr_pkg::CMD_TARE || cmd == lcr_pkg::CMD_WEIGH) begin
					tare_cmd_d = (cmd == lcr_pkg::CMD_TARE);
					phase_d    = lcr_pkg::PH_WAIT;
				end
			end
			lcr_pkg::PH_WAIT: begin
				// A low data pin means a conversion is ready to be shifted out.
				if (!data_pin) begin
					cnt_d   = '0;
					shift_d = '0;
					phase_d = lcr_pkg::PH_HIGH;
				end
			end
			lcr_pkg::PH_HIGH: begin
				clk_level = 1'b1;
				phase_d   = lcr_pkg::PH_LOW;
			end
			lcr_pkg::PH_LOW: begin
				if (cnt_q < CNT_W'(RAW_BITS)) begin
					shift_d = {shift_q[RAW_BITS-2:0], data_pin};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_d >= CNT_W'(TOTAL)) begin
					last_raw_d = shift_d ^ TOP_BIT;
					if (tare_cmd_q) begin
						tare_d = last_raw_d;
						tared  = 1'b1;
					end else if (last_raw_d > tare_q) begin
						div_req = 1'b1;
					end
					cnt_d   = '0;
					phase_d = lcr_pkg::PH_IDLE;
				end else begin
					phase_d = lcr_pkg::PH_HIGH;
				end
			end
			default: begin
				phase_d = lcr_pkg::PH_IDLE;
			end
		endcase
	end

	assign diff    = last_raw_d - tare_q;
	assign raw_ext = lcr_pkg::RAW_MAX_W'(last_raw_d);

	always_comb begin
		job.clock_pin = clk_level;
		job.busy      = (phase_d != lcr_pkg::PH_IDLE);
		job.tare_done = tared;
		job.div_req   = div_req;
		job.raw       = raw_ext[lcr_pkg::OUT_W-1:0];
		job.diff      = lcr_pkg::RAW_MAX_W'(diff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lcr_pkg::PH_IDLE;
			cnt_q      <= '0;
			shift_q    <= '0;
			tare_cmd_q <= 1'b0;
			tare_q     <= '0;
			last_raw_q <= '0;
		end else if (push) begin
			phase_q    <= phase_d;
			cnt_q      <= cnt_d;
			shift_q    <= shift_d;
			tare_cmd_q <= tare_cmd_d;
			tare_q     <= tare_d;
			last_raw_q <= last_raw_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lcr_fifo.sv =====
// ============================================================================
// Load cell reader job queue
// Two-entry queue that decouples the tick sequencer from the divider.
// ============================================================================
`default_nettype none

module lcr_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire lcr_pkg::job_t push_job,
	input  wire logic          pop,
	output logic               full,
	output logic               empty,
	output lcr_pkg::job_t      head
);

	lcr_pkg::job_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/lcr_back.sv =====
// ============================================================================
// Load cell reader back end
// Holds the calibration divisor, divides one quotient bit per cycle and
// drives the result register.
// ============================================================================
`default_nettype none

module lcr_back #(
	parameter int RAW_BITS = lcr_pkg::RAW_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [lcr_pkg::GAP_W-1:0] cfg_data,
	input  wire logic                      queue_empty,
	input  wire lcr_pkg::job_t             head,
	output logic                           pop,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [55:0]                    out_data
);

	localparam int QW     = RAW_BITS + 1;
	localparam int DCNT_W = $clog2(QW + 1);
	localparam int GW     = lcr_pkg::GAP_W;
	localparam int OW     = lcr_pkg::OUT_W;

	lcr_pkg::back_state_t state_q, state_d;
	logic [GW-1:0]     gap_q;
	logic [QW-1:0]     dvd_q;
	logic [GW-1:0]     rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              hold_clk_q;
	logic              hold_busy_q;
	logic [OW-1:0]     hold_raw_q;
	logic [OW-1:0]     weight_q;
	logic              ov_q;
	logic              o_clk_q;
	logic              o_busy_q;
	logic [OW-1:0]     o_raw_q;
	logic              o_upd_q;
	logic              o_tare_q;

	logic              out_free;
	logic              load_plain;
	logic              load_div;
	logic              div_last;
	logic              finish;
	logic [GW:0]       rem_sh;
	logic              ge;
	logic [GW:0]       rem_sub;
	logic [lcr_pkg::EXT_W-1:0] q_ext;
	logic              q_over;
	logic [OW-1:0]     quotient;

	assign cfg_ready = 1'b1;
	assign out_free  = !ov_q || out_ready;

	// Restoring divide step: bring down one dividend bit, subtract if it fits.
	assign rem_sh  = {rem_q, dvd_q[QW-1]};
	assign ge      = (rem_sh >= {1'b0, gap_q});
	assign rem_sub = rem_sh - {1'b0, gap_q};
	assign div_last = (dcnt_q == DCNT_W'(QW - 1));

	assign q_ext    = lcr_pkg::EXT_W'(dvd_q);
	assign q_over   = |q_ext[lcr_pkg::EXT_W-1:OW] || (gap_q == '0);
	assign quotient = q_over ? {OW{1'b1}} : q_ext[OW-1:0];

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		load_plain = 1'b0;
		load_div   = 1'b0;
		finish     = 1'b0;
		unique case (state_q)
			lcr_pkg::BK_RUN: begin
				if (!queue_empty) begin
					if (head.div_req) begin
						pop      = 1'b1;
						load_div = 1'b1;
						state_d  = lcr_pkg::BK_DIV;
					end else if (out_free) begin
						pop        = 1'b1;
						load_plain = 1'b1;
					end
				end
			end
			lcr_pkg::BK_DIV: begin
				if (div_last) begin
					state_d = lcr_pkg::BK_DONE;
				end
			end
			lcr_pkg::BK_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = lcr_pkg::BK_RUN;
				end
			end
			default: begin
				state_d = lcr_pkg::BK_RUN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lcr_pkg::BK_RUN;
			gap_q    <= lcr_pkg::GAP_RESET;
			weight_q <= '0;
			ov_q     <= 1'b0;
			dcnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				gap_q <= cfg_data;
			end
			if (load_div) begin
				dcnt_q <= '0;
			end else if (state_q == lcr_pkg::BK_DIV) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (finish) begin
				weight_q <= quotient;
			end
			if (load_plain || finish) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_div) begin
			dvd_q       <= {head.diff[RAW_BITS-1:0], 1'b0};
			rem_q       <= '0;
			hold_clk_q  <= head.clock_pin;
			hold_busy_q <= head.busy;
			hold_raw_q  <= head.raw;
		end else if (state_q == lcr_pkg::BK_DIV) begin
			dvd_q <= {dvd_q[QW-2:0], ge};
			rem_q <= ge ? rem_sub[GW-1:0] : rem_sh[GW-1:0];
		end
		if (load_plain) begin
			o_clk_q  <= head.clock_pin;
			o_busy_q <= head.busy;
			o_raw_q  <= head.raw;
			o_upd_q  <= 1'b0;
			o_tare_q <= head.tare_done;
		end else if (finish) begin
			o_clk_q  <= hold_clk_q;
			o_busy_q <= hold_busy_q;
			o_raw_q  <= hold_raw_q;
			o_upd_q  <= 1'b1;
			o_tare_q <= 1'b0;
		end
	end

	// The plain path shows the held weight; the divide path shows the new one.
	logic [OW-1:0] o_weight;
	assign o_weight  = o_upd_q ? weight_q : weight_q;
	assign out_valid = ov_q;
	assign out_data  = {4'b0, o_tare_q, o_upd_q, o_weight, o_raw_q, o_busy_q, o_clk_q};

endmodule

`default_nettype wire

// ===== rtl/core/load_cell_adc_reader_with_tare.sv =====
// ============================================================================
// Load cell converter reader with tare
// Two-wire serial converter reader: one input beat per half-bit tick,
// tare capture and calibrated weight by an iterative divider.
// ============================================================================
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser command, s_tdata data_pin
//  m_      | out | m_tvalid/m_tready  | m_tdata one result per tick
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data gap_halves (reset 213)
//
// Each tick beat is sequenced in the cycle it is accepted; its job is written to
// the queue and then to the result register, which offers the result beat. The
// tick that ends a weigh above tare runs the restoring divider, one quotient
// bit per cycle, before its result is written to the result register.
// Reset is asynchronous and clears all control state; no clearing pass.
// The two-entry queue takes two more ticks while the divider runs or the result
// register stalls, and then s_tready stays low until an entry drains.
// ============================================================================
`default_nettype none

module load_cell_adc_reader_with_tare #(
	parameter int RAW_BITS     = lcr_pkg::RAW_BITS_DEF,
	parameter int EXTRA_PULSES = lcr_pkg::EXTRA_PULSES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [0] data_pin, [7:1] zero
	input  wire logic [1:0]  s_tuser,   // [1:0] command
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [55:0]      m_tdata,   // [0] clock_pin, [1] busy_res, [25:2] raw_value,
	                                    // [49:26] weight, [50] weight_updated,
	                                    // [51] tare_done, [55:52] zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	lcr_pkg::job_t push_job;
	lcr_pkg::job_t head;

	lcr_front #(
		.RAW_BITS     (RAW_BITS),
		.EXTRA_PULSES (EXTRA_PULSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (s_tvalid),
		.tick_ready (s_tready),
		.command    (s_tuser),
		.data_pin   (s_tdata[0]),
		.queue_full (full),
		.push       (push),
		.job        (push_job)
	);

	lcr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	lcr_back #(
		.RAW_BITS (RAW_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.queue_empty (empty),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata)
	);

endmodule

`default_nettype wire
